// ===== sv/assert_macros.svh =====
// Assertion macros shared by the plane-wave field RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset
`define PWF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Antecedent on one edge, consequent on the next
`define PWF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pwf_pkg.sv =====
// Shared types and constants for the plane-wave field block
`timescale 1ns / 1ps
`default_nettype none

package pwf_pkg;

    // Register port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Phase is a 32-bit fraction of a turn
    localparam int PHASE_W = 32;

    // Field parts: signed Q1.15
    localparam int FIELD_W   = 16;
    localparam int FRAC_BITS = 15;
    typedef logic signed [FIELD_W-1:0] field_t;

    // CORDIC datapath
    localparam int CORDIC_ITERS = 16;
    localparam int CORDIC_W     = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = CORDIC_W'(652032874);

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [PHASE_W-1:0] ATAN_TURNS [CORDIC_ITERS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354466,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861
    };

endpackage

`default_nettype wire

// ===== sv/pwf_if.sv =====
// Valid/ready channel interfaces: lattice site in, field result out
`timescale 1ns / 1ps
`default_nettype none

interface pwf_site_if #(
    parameter int COORD_BITS = 11
) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] coord_x;
    logic [COORD_BITS-1:0] coord_y;
    logic [COORD_BITS-1:0] coord_z;

    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    input ready);
    modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                    output ready);
endinterface

interface pwf_field_if import pwf_pkg::*; ();
    logic   valid;
    logic   ready;
    field_t ex_re;
    field_t ex_im;
    field_t ey_re;
    field_t ey_im;
    field_t ez_re;
    field_t ez_im;

    modport source (output valid, output ex_re, output ex_im, output ey_re,
                    output ey_im, output ez_re, output ez_im, input ready);
    modport sink   (input valid, input ex_re, input ex_im, input ey_re,
                    input ey_im, input ez_re, input ez_im, output ready);
endinterface

`default_nettype wire

// ===== sv/plane_wave_field_at_lattice_site_top.sv =====
// Top level: plane-wave incident field at one lattice site, fully pipelined
//
// Channels: site (sink) carries coord_x/y/z of one lattice site; field (source)
// carries ex/ey/ez real and imaginary parts, signed Q1.15, saturated. Both use
// valid/ready; a transaction completes on a rising edge with both high.
// Write the registers through cfg_we/cfg_index/cfg_data only while the block is
// idle; the block itself does not enforce this. Index 0..6 = step x, step y,
// step z, offset, field x, y, z. Throughput: one site per clock while the
// receiver takes results. Results pass through 3 phase stages, a 16-stage
// CORDIC (one rotation per stage), 2 phasor stages, one multiply stage and
// the round/saturate output register.
// Reset clears the configuration registers and valid bits to zero, emptying the pipeline.
// Stall: every stage carries a valid bit and only holds while the stage after
// it is full and holding, so bubbles close up under a stalled receiver and new
// sites are still taken until all 23 stages are full.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module plane_wave_field_at_lattice_site_top import pwf_pkg::*; #(
    parameter int COORD_BITS = 11,
    parameter int PHASE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    pwf_site_if.sink              site,
    pwf_field_if.source           field
);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_Z = 3'd6;

    // Quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Pipeline stage positions
    localparam int ST_PROD = 0;
    localparam int ST_SUM  = 1;
    localparam int ST_PH   = 2;
    localparam int ST_CRD0 = 3;
    localparam int ST_ROT  = ST_CRD0 + CORDIC_ITERS;
    localparam int ST_RND  = ST_ROT + 1;
    localparam int ST_MUL  = ST_RND + 1;
    localparam int ST_OUT  = ST_MUL + 1;
    localparam int N_ST    = ST_OUT + 1;

    // Phase constants
    localparam logic [PHASE_W:0]   LOW_ONES     = (33'd1 << (PHASE_W - PHASE_BITS)) - 33'd1;
    localparam logic [PHASE_W-1:0] PHASE_MASK   = ~LOW_ONES[PHASE_W-1:0];
    localparam logic [PHASE_W-1:0] OCTANT_BIAS  = 32'h2000_0000;
    localparam int                 N_COMP       = 3;
    localparam int                 PROD_W       = 2 * FIELD_W;
    localparam int                 SUM_W        = PROD_W + 1;

    // Rounding and saturation
    localparam int                        RND_W    = CORDIC_W + 1;
    localparam logic signed [RND_W-1:0]   RND_BIAS = RND_W'(16384);
    localparam logic signed [RND_W-1:0]   SAT_MAX  = RND_W'(32767);
    localparam logic signed [RND_W-1:0]   SAT_MIN  = -(RND_W'(32768));
    localparam field_t                    FIELD_MAX = 16'sh7FFF;
    localparam field_t                    FIELD_MIN = 16'sh8000;

    // Range limits used by the checks
    localparam logic signed [CORDIC_W-1:0] RESID_LIM = CORDIC_W'(536870912);
    localparam logic signed [CORDIC_W-1:0] ZEND_LIM  = CORDIC_W'(41722);

    function automatic field_t round_sat(input logic signed [RND_W-1:0] v);
        logic signed [RND_W-1:0] t;
        logic signed [RND_W-1:0] sh;
        t  = v + RND_BIAS;
        sh = t >>> FRAC_BITS;
        if (sh > SAT_MAX)
            return FIELD_MAX;
        else if (sh < SAT_MIN)
            return FIELD_MIN;
        else
            return sh[FIELD_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [PHASE_W-1:0]    step_x_reg;
    logic [PHASE_W-1:0]    step_y_reg;
    logic [PHASE_W-1:0]    step_z_reg;
    logic [PHASE_W-1:0]    offset_reg;
    logic [CFG_DATA_W-1:0] field_reg [N_COMP];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_x_reg   <= '0;
            step_y_reg   <= '0;
            step_z_reg   <= '0;
            offset_reg   <= '0;
            field_reg[0] <= '0;
            field_reg[1] <= '0;
            field_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STEP_X:  step_x_reg   <= cfg_data;
                CFG_STEP_Y:  step_y_reg   <= cfg_data;
                CFG_STEP_Z:  step_z_reg   <= cfg_data;
                CFG_OFFSET:  offset_reg   <= cfg_data;
                CFG_FIELD_X: field_reg[0] <= cfg_data;
                CFG_FIELD_Y: field_reg[1] <= cfg_data;
                CFG_FIELD_Z: field_reg[2] <= cfg_data;
                default:     ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Valid bits and per-stage advance (bubbles collapse under stall)
    // ------------------------------------------------------------------
    logic [N_ST-1:0] v_reg;
    logic [N_ST-1:0] v_next;
    logic [N_ST-1:0] v_in;
    logic [N_ST-1:0] adv;

    assign adv[N_ST-1] = !v_reg[N_ST-1] || field.ready;
    for (genvar k = 0; k < N_ST - 1; k++)
    begin : g_adv
        assign adv[k] = !v_reg[k] || adv[k+1];
    end

    assign v_in   = {v_reg[N_ST-2:0], site.valid};
    assign v_next = (adv & v_in) | (~adv & v_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign site.ready  = adv[ST_PROD];
    assign field.valid = v_reg[ST_OUT];

    // ------------------------------------------------------------------
    // Phase: per-axis products, partial sums, octant reduction
    // ------------------------------------------------------------------
    logic [PHASE_W+COORD_BITS-1:0] prod_x_full;
    logic [PHASE_W+COORD_BITS-1:0] prod_y_full;
    logic [PHASE_W+COORD_BITS-1:0] prod_z_full;
    logic [PHASE_W-1:0]            prod_x_reg;
    logic [PHASE_W-1:0]            prod_y_reg;
    logic [PHASE_W-1:0]            prod_z_reg;
    logic [PHASE_W-1:0]            sum_a_next;
    logic [PHASE_W-1:0]            sum_b_next;
    logic [PHASE_W-1:0]            sum_a_reg;
    logic [PHASE_W-1:0]            sum_b_reg;
    logic [PHASE_W-1:0]            phase_next;
    logic [PHASE_W-1:0]            biased;
    logic [PHASE_W-1:0]            resid;
    logic [1:0]                    ph_q_next;
    logic signed [CORDIC_W-1:0]    ph_z_next;
    logic [1:0]                    ph_q_reg;
    logic signed [CORDIC_W-1:0]    ph_z_reg;

    assign prod_x_full = step_x_reg * site.coord_x[COORD_BITS-1:0];
    assign prod_y_full = step_y_reg * site.coord_y[COORD_BITS-1:0];
    assign prod_z_full = step_z_reg * site.coord_z[COORD_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (adv[ST_PROD])
        begin
            prod_x_reg <= prod_x_full[PHASE_W-1:0];
            prod_y_reg <= prod_y_full[PHASE_W-1:0];
            prod_z_reg <= prod_z_full[PHASE_W-1:0];
        end
    end

    assign sum_a_next = offset_reg + prod_x_reg;
    assign sum_b_next = prod_y_reg + prod_z_reg;

    always_ff @(posedge clk)
    begin
        if (adv[ST_SUM])
        begin
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
    end

    // Nearest quarter turn and signed residual in [-1/8, 1/8) turn
    assign phase_next = (sum_a_reg + sum_b_reg) & PHASE_MASK;
    assign biased     = phase_next + OCTANT_BIAS;
    assign ph_q_next  = biased[PHASE_W-1:PHASE_W-2];
    assign resid      = phase_next - {ph_q_next, 30'd0};
    assign ph_z_next  = signed'({{(CORDIC_W-PHASE_W){resid[PHASE_W-1]}}, resid});

    always_ff @(posedge clk)
    begin
        if (adv[ST_PH])
        begin
            ph_q_reg <= ph_q_next;
            ph_z_reg <= ph_z_next;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC rotation, one iteration per stage
    // ------------------------------------------------------------------
    logic signed [CORDIC_W-1:0] cx_out [CORDIC_ITERS];
    logic signed [CORDIC_W-1:0] cy_out [CORDIC_ITERS];
    logic signed [CORDIC_W-1:0] cz_out [CORDIC_ITERS];
    logic [1:0]                 cq_out [CORDIC_ITERS];

    for (genvar i = 0; i < CORDIC_ITERS; i++)
    begin : g_cordic
        logic signed [CORDIC_W-1:0] x_in;
        logic signed [CORDIC_W-1:0] y_in;
        logic signed [CORDIC_W-1:0] z_in;
        logic [1:0]                 q_in;
        logic signed [CORDIC_W-1:0] x_sh;
        logic signed [CORDIC_W-1:0] y_sh;
        logic signed [CORDIC_W-1:0] ang;
        logic signed [CORDIC_W-1:0] x_next;
        logic signed [CORDIC_W-1:0] y_next;
        logic signed [CORDIC_W-1:0] z_next;
        logic signed [CORDIC_W-1:0] x_reg;
        logic signed [CORDIC_W-1:0] y_reg;
        logic signed [CORDIC_W-1:0] z_reg;
        logic [1:0]                 q_reg;

        if (i == 0)
        begin : g_first
            assign x_in = CORDIC_X0;
            assign y_in = '0;
            assign z_in = ph_z_reg;
            assign q_in = ph_q_reg;
        end
        else
        begin : g_rest
            assign x_in = cx_out[i-1];
            assign y_in = cy_out[i-1];
            assign z_in = cz_out[i-1];
            assign q_in = cq_out[i-1];
        end

        assign x_sh = y_in >>> i;
        assign y_sh = x_in >>> i;
        assign ang  = signed'({{(CORDIC_W-PHASE_W){1'b0}}, ATAN_TURNS[i]});

        // Rotate towards zero residual angle
        always_comb
        begin
            if (!z_in[CORDIC_W-1])
            begin
                x_next = x_in - x_sh;
                y_next = y_in + y_sh;
                z_next = z_in - ang;
            end
            else
            begin
                x_next = x_in + x_sh;
                y_next = y_in - y_sh;
                z_next = z_in + ang;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[ST_CRD0+i])
            begin
                x_reg <= x_next;
                y_reg <= y_next;
                z_reg <= z_next;
                q_reg <= q_in;
            end
        end

        assign cx_out[i] = x_reg;
        assign cy_out[i] = y_reg;
        assign cz_out[i] = z_reg;
        assign cq_out[i] = q_reg;
    end

    // ------------------------------------------------------------------
    // Quadrant rotation, then round to the Q1.15 phasor
    // ------------------------------------------------------------------
    logic signed [CORDIC_W-1:0] rot_c_next;
    logic signed [CORDIC_W-1:0] rot_s_next;
    logic signed [CORDIC_W-1:0] rot_c_reg;
    logic signed [CORDIC_W-1:0] rot_s_reg;
    field_t                     cos_reg;
    field_t                     sin_reg;

    always_comb
    begin
        case (cq_out[CORDIC_ITERS-1])
            QUAD_0:
            begin
                rot_c_next = cx_out[CORDIC_ITERS-1];
                rot_s_next = cy_out[CORDIC_ITERS-1];
            end
            QUAD_1:
            begin
                rot_c_next = -cy_out[CORDIC_ITERS-1];
                rot_s_next = cx_out[CORDIC_ITERS-1];
            end
            QUAD_2:
            begin
                rot_c_next = -cx_out[CORDIC_ITERS-1];
                rot_s_next = -cy_out[CORDIC_ITERS-1];
            end
            QUAD_3:
            begin
                rot_c_next = cy_out[CORDIC_ITERS-1];
                rot_s_next = -cx_out[CORDIC_ITERS-1];
            end
            default:
            begin
                rot_c_next = cx_out[CORDIC_ITERS-1];
                rot_s_next = cy_out[CORDIC_ITERS-1];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_ROT])
        begin
            rot_c_reg <= rot_c_next;
            rot_s_reg <= rot_s_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_RND])
        begin
            cos_reg <= round_sat({rot_c_reg[CORDIC_W-1], rot_c_reg});
            sin_reg <= round_sat({rot_s_reg[CORDIC_W-1], rot_s_reg});
        end
    end

    // ------------------------------------------------------------------
    // Complex multiply of each field component by the phasor
    // ------------------------------------------------------------------
    field_t out_re [N_COMP];
    field_t out_im [N_COMP];

    for (genvar k = 0; k < N_COMP; k++)
    begin : g_cmul
        field_t                   fa;
        field_t                   fb;
        logic signed [PROD_W-1:0] ac_reg;
        logic signed [PROD_W-1:0] bs_reg;
        logic signed [PROD_W-1:0] as_reg;
        logic signed [PROD_W-1:0] bc_reg;
        logic signed [SUM_W-1:0]  re_next;
        logic signed [SUM_W-1:0]  im_next;
        field_t                   re_reg;
        field_t                   im_reg;

        assign fa = field_reg[k][FIELD_W-1:0];
        assign fb = field_reg[k][2*FIELD_W-1:FIELD_W];

        always_ff @(posedge clk)
        begin
            if (adv[ST_MUL])
            begin
                ac_reg <= fa * cos_reg;
                bs_reg <= fb * sin_reg;
                as_reg <= fa * sin_reg;
                bc_reg <= fb * cos_reg;
            end
        end

        assign re_next = {ac_reg[PROD_W-1], ac_reg} - {bs_reg[PROD_W-1], bs_reg};
        assign im_next = {as_reg[PROD_W-1], as_reg} + {bc_reg[PROD_W-1], bc_reg};

        // Output register
        always_ff @(posedge clk)
        begin
            if (adv[ST_OUT])
            begin
                re_reg <= round_sat({{(RND_W-SUM_W){re_next[SUM_W-1]}}, re_next});
                im_reg <= round_sat({{(RND_W-SUM_W){im_next[SUM_W-1]}}, im_next});
            end
        end

        assign out_re[k] = re_reg;
        assign out_im[k] = im_reg;
    end

    assign field.ex_re = out_re[0];
    assign field.ex_im = out_im[0];
    assign field.ey_re = out_re[1];
    assign field.ey_im = out_im[1];
    assign field.ez_re = out_re[2];
    assign field.ez_im = out_im[2];

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `PWF_ASSERT(a_full_stall, (&v_reg && !field.ready) |-> !site.ready, "full pipe took a site")
    `PWF_ASSERT_NEXT(a_occupancy, 1'b1, $countones(v_reg) <= $past($countones(v_reg)) + 1, "items appeared in the pipe")
    `PWF_ASSERT(a_resid_range, v_reg[ST_PH] |-> (ph_z_reg >= -RESID_LIM && ph_z_reg < RESID_LIM), "residual outside one octant")
    `PWF_ASSERT(a_cordic_conv, v_reg[ST_ROT-1] |-> (cz_out[CORDIC_ITERS-1] <= ZEND_LIM && cz_out[CORDIC_ITERS-1] >= -ZEND_LIM), "CORDIC did not converge")

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the plane-wave field block: directed and random lattice sites
`timescale 1ns / 1ps

module tb;
    import pwf_pkg::*;

    localparam int COORD_BITS = 11;
    localparam int PHASE_BITS = 32;
    localparam int HALF_PERIOD = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 40;
    localparam int LONG_HOLD = 80;
    localparam logic [PHASE_W-1:0] PHASE_KEEP = '1 << (PHASE_W - PHASE_BITS);
    localparam longint ROTOR_GAIN = 652032874;
    localparam longint ROTOR_ANGLE [16] = '{
        536870912, 316933406, 167458907, 85004756,
        42667331, 21354466, 10679838, 5340245,
        2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    typedef logic [COORD_BITS-1:0] coord_t;
    // index 0 = ex_re, 1 = ex_im, 2 = ey_re, 3 = ey_im, 4 = ez_re, 5 = ez_im
    typedef logic [5:0][FIELD_W-1:0] site_field_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_X,
        REG_STEP_Y,
        REG_STEP_Z,
        REG_OFFSET,
        REG_FIELD_X,
        REG_FIELD_Y,
        REG_FIELD_Z,
        REG_UNUSED
    } reg_index_e;

    // Register mirror, field predictor and store of outstanding expectations
    class incident_field_book;
        logic [31:0] step_x, step_y, step_z, offset;
        logic [31:0] field_x, field_y, field_z;
        site_field_t expected_fields[$];
        int errors;
        int results_seen;

        function new();
            step_x = '0; step_y = '0; step_z = '0; offset = '0;
            field_x = '0; field_y = '0; field_z = '0;
            errors = 0;
            results_seen = 0;
        endfunction

        function void set_register(reg_index_e idx, logic [31:0] data);
            case (idx)
                REG_STEP_X:  step_x = data;
                REG_STEP_Y:  step_y = data;
                REG_STEP_Z:  step_z = data;
                REG_OFFSET:  offset = data;
                REG_FIELD_X: field_x = data;
                REG_FIELD_Y: field_y = data;
                REG_FIELD_Z: field_z = data;
                default: ;
            endcase
        endfunction

        // Round to Q1.15 with half-up and clamp to 16 bits
        function longint round_sat(longint v);
            longint t;
            t = (v + 16384) >>> 15;
            if (t > 32767)
                return 32767;
            if (t < -32768)
                return -32768;
            return t;
        endfunction

        // Octant reduction, 16 CORDIC rotations, then exact quarter turns
        function void unit_phasor(logic [31:0] p, output longint c, output longint s);
            logic [31:0] shifted;
            logic [1:0]  quad;
            logic [31:0] resid;
            longint z, x, y, nx, ny;
            shifted = p + 32'h2000_0000;
            quad = shifted[31:30];
            resid = p - {quad, 30'b0};
            z = $signed(resid);
            x = ROTOR_GAIN;
            y = 0;
            for (int i = 0; i < 16; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    z -= ROTOR_ANGLE[i];
                end
                else
                begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    z += ROTOR_ANGLE[i];
                end
                x = nx;
                y = ny;
            end
            case (quad)
                2'd0: begin c = x;  s = y;  end
                2'd1: begin c = -y; s = x;  end
                2'd2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
            c = round_sat(c);
            s = round_sat(s);
        endfunction

        // Complex product; returns imaginary in the high half, real in the low
        function logic [31:0] rotate_field(logic [31:0] incident, longint c, longint s);
            longint a, b, re, im;
            a = $signed(incident[15:0]);
            b = $signed(incident[31:16]);
            re = round_sat(a * c - b * s);
            im = round_sat(a * s + b * c);
            return {im[15:0], re[15:0]};
        endfunction

        function site_field_t field_at_site(coord_t cx, coord_t cy, coord_t cz);
            logic [31:0] p;
            longint c, s;
            site_field_t res;
            p = offset + step_x * cx + step_y * cy + step_z * cz;
            p &= PHASE_KEEP;
            unit_phasor(p, c, s);
            {res[1], res[0]} = rotate_field(field_x, c, s);
            {res[3], res[2]} = rotate_field(field_y, c, s);
            {res[5], res[4]} = rotate_field(field_z, c, s);
            return res;
        endfunction

        function void note_site(coord_t cx, coord_t cy, coord_t cz);
            expected_fields.push_back(field_at_site(cx, cy, cz));
        endfunction

        function int pending();
            return expected_fields.size();
        endfunction

        function string part_name(int k);
            case (k)
                0: return "ex_re";
                1: return "ex_im";
                2: return "ey_re";
                3: return "ey_im";
                4: return "ez_re";
                default: return "ez_im";
            endcase
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        task check_field(site_field_t got);
            site_field_t want;
            if (expected_fields.size() == 0)
            begin
                report($sformatf("result %0d arrived with no site outstanding", results_seen));
            end
            else
            begin
                want = expected_fields.pop_front();
                for (int k = 0; k < 6; k++)
                    if (got[k] !== want[k])
                        report($sformatf("result %0d %s: got %0d, expected %0d",
                                         results_seen, part_name(k),
                                         $signed(got[k]), $signed(want[k])));
            end
            results_seen++;
        endtask

        task check_drained();
            if (expected_fields.size() != 0)
                report($sformatf("%0d results never arrived", expected_fields.size()));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pwf_site_if #(.COORD_BITS(COORD_BITS)) site_ch ();
    pwf_field_if field_ch ();

    incident_field_book book;
    int  src_idle_pct;
    int  snk_idle_pct;
    bit  long_hold_req;
    int  cycles;

    plane_wave_field_at_lattice_site_top #(
        .COORD_BITS(COORD_BITS),
        .PHASE_BITS(PHASE_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .site      (site_ch),
        .field     (field_ch)
    );

    // Clock
    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    // Watchdog
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: check each transaction, then choose next ready
    initial
    begin
        int hold_left;
        site_field_t got;
        hold_left = 0;
        field_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && field_ch.valid && field_ch.ready)
            begin
                got = {field_ch.ez_im, field_ch.ez_re, field_ch.ey_im,
                       field_ch.ey_re, field_ch.ex_im, field_ch.ex_re};
                book.check_field(got);
            end
            if (long_hold_req)
            begin
                hold_left = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                field_ch.ready <= 1'b0;
            end
            else
                field_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Offer one site, with random gaps, until the transaction completes
    task automatic send_site(coord_t cx, coord_t cy, coord_t cz);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            site_ch.valid <= 1'b0;
            @(posedge clk);
        end
        site_ch.valid   <= 1'b1;
        site_ch.coord_x <= cx;
        site_ch.coord_y <= cy;
        site_ch.coord_z <= cz;
        @(posedge clk);
        while (!site_ch.ready)
            @(posedge clk);
        book.note_site(cx, cy, cz);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic end_burst();
        site_ch.valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(reg_index_e idx, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        book.set_register(idx, data);
    endtask

    // Write all seven registers, sometimes with a stray write to the unused index
    task automatic load_registers(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                                  logic [31:0] off, logic [31:0] fx, logic [31:0] fy,
                                  logic [31:0] fz);
        write_register(REG_STEP_X, sx);
        write_register(REG_STEP_Y, sy);
        write_register(REG_STEP_Z, sz);
        write_register(REG_OFFSET, off);
        if ($urandom_range(0, 1) == 0)
            write_register(REG_UNUSED, $urandom());
        write_register(REG_FIELD_X, fx);
        write_register(REG_FIELD_Y, fy);
        write_register(REG_FIELD_Z, fz);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'h1 << $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] pick_half();
        case ($urandom_range(0, 6))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic coord_t pick_coord();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return coord_t'($urandom_range(0, (1 << COORD_BITS) - 1));
        endcase
    endfunction

    task automatic random_burst(int count);
        load_registers(pick_word(), pick_word(), pick_word(), pick_word(),
                       {pick_half(), pick_half()}, {pick_half(), pick_half()},
                       {pick_half(), pick_half()});
        repeat (count)
            send_site(pick_coord(), pick_coord(), pick_coord());
        end_burst();
    endtask

    // Stimulus
    initial
    begin
        book = new();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        long_hold_req = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        site_ch.valid = 1'b0;
        site_ch.coord_x = '0;
        site_ch.coord_y = '0;
        site_ch.coord_z = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers at reset: every field is zero
        send_site('0, '0, '0);
        send_site('1, '1, '1);
        end_burst();

        // Quarter and eighth turns, phasor of magnitude one, product overflow
        write_register(REG_UNUSED, 32'hFFFF_FFFF);
        load_registers(32'h0100_0000, 32'h4000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                       32'h0000_7FFF, 32'h8000_8000, 32'h8000_7FFF);
        send_site(11'd0, 11'd0, 11'd0);
        send_site(11'd0, 11'd1, 11'd0);
        send_site(11'd0, 11'd2, 11'd0);
        send_site(11'd0, 11'd3, 11'd0);
        send_site(11'd32, 11'd0, 11'd0);
        send_site(11'd0, 11'd0, 11'd1);
        send_site(11'd2047, 11'd0, 11'd0);
        send_site(11'd0, 11'd2047, 11'd0);
        send_site(11'd0, 11'd0, 11'd2047);
        send_site(11'h555, 11'h2AA, 11'h555);
        send_site(11'h2AA, 11'h555, 11'h2AA);
        send_site(11'd2047, 11'd2047, 11'd2047);
        end_burst();

        // Phases either side of an octant boundary
        load_registers(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'h1FFF_FFFF,
                       32'h7FFF_7FFF, 32'h7FFF_8000, 32'h0001_FFFF);
        send_site(11'd0, 11'd0, 11'd0);
        send_site(11'd1, 11'd0, 11'd0);
        send_site(11'd2, 11'd0, 11'd0);
        send_site(11'd0, 11'd1, 11'd0);
        send_site(11'd2047, 11'd2047, 11'd0);
        end_burst();

        // Random sites: slow receiver, then slow sender, then full rate
        src_idle_pct = 9;
        snk_idle_pct = 65;
        repeat (6) random_burst(55);

        src_idle_pct = 65;
        snk_idle_pct = 9;
        repeat (6) random_burst(55);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        repeat (5) random_burst(55);

        // Receiver stalls for a long stretch while sites keep coming
        load_registers(pick_word(), pick_word(), pick_word(), pick_word(),
                       $urandom(), $urandom(), $urandom());
        long_hold_req = 1'b1;
        repeat (60)
            send_site(pick_coord(), pick_coord(), pick_coord());
        end_burst();
        random_burst(55);

        repeat (TAIL_CYCLES) @(posedge clk);
        book.check_drained();
        if (book.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
